@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the queue pair RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in the same cycle.
`define NVQP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define NVQP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/nvqp_pkg.sv @@
// Shared types, codes and helpers for the NVMe I/O queue pair host block.
// No dependencies.
package nvqp_pkg;

  localparam int unsigned QueueDepth = 1024;
  localparam int unsigned IdxW       = 10;
  localparam logic [63:0] PageBytes  = 64'd4096;
  localparam logic [18:0] DbBase     = 19'h01000;
  localparam logic [1:0]  SqDbSlot   = 2'd2;
  localparam logic [1:0]  CqDbSlot   = 2'd3;
  localparam int unsigned JobqDepth  = 4;

  // input actions
  localparam logic [1:0] ActRead   = 2'd0;
  localparam logic [1:0] ActWrite  = 2'd1;
  localparam logic [1:0] ActStatus = 2'd2;

  // result kinds
  localparam logic [1:0] ResEntry  = 2'd0;
  localparam logic [1:0] ResSqDb   = 2'd1;
  localparam logic [1:0] ResCqDb   = 2'd2;
  localparam logic [1:0] ResCmd    = 2'd3;

  localparam logic [7:0] OpRead    = 8'h02;
  localparam logic [7:0] OpWrite   = 8'h01;

  // configuration register indexes
  localparam int unsigned CfgIdxW  = 3;
  localparam logic [CfgIdxW-1:0] CfgReady  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgNsid   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBsl    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStride = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPoll   = 3'd4;

  localparam logic [4:0]  BslReset  = 5'd9;
  localparam logic [19:0] PollReset = 20'd1000000;

  typedef struct packed {
    logic        ready;
    logic [31:0] nsid;
    logic [4:0]  bsl;
    logic [3:0]  stride;
    logic [19:0] poll_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    JobSubmit,
    JobComplete,
    JobFail
  } job_kind_e;

  typedef struct packed {
    job_kind_e       kind;
    logic            write;
    logic [IdxW-1:0] slot;
    logic [IdxW-1:0] new_idx;
    logic            ok;
    logic            prp2_en;
    logic [63:0]     buf_addr;
    logic [63:0]     lba;
    logic [15:0]     dw12;
  } job_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [IdxW-1:0] idx;
    logic [7:0]      opcode;
    logic [31:0]     nsid;
    logic [63:0]     prp1;
    logic [63:0]     prp2;
    logic [31:0]     dw10;
    logic [31:0]     dw11;
    logic [15:0]     dw12;
    logic [18:0]     db_off;
    logic            ok;
    logic            last;
  } res_t;

  function automatic logic [18:0] db_offset(logic [1:0] slot, logic [3:0] stride);
    logic [18:0] spaced;
    spaced = {15'd0, slot, 2'b00} << stride;
    return DbBase + spaced;
  endfunction

endpackage

@@ rtl/core/nvqp_front.sv @@
// Front end: accepts input beats, tracks queue state and classifies each beat
// into a job for the back end. Depends on nvqp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module nvqp_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  nvqp_pkg::cfg_t            cfg_i,
  input  logic                      push_i,
  input  logic                      full_i,
  input  logic [1:0]                action_i,
  input  logic [63:0]               lba_i,
  input  logic [16:0]               block_count_i,
  input  logic [63:0]               buffer_address_i,
  input  logic [15:0]               completion_status_i,
  output logic                      job_valid_o,
  output nvqp_pkg::job_t            job_o
);
  import nvqp_pkg::*;

  logic [IdxW-1:0] tail_q, tail_d, head_q, head_d;
  logic            phase_q, phase_d;
  logic [19:0]     polls_q, polls_d;
  logic            busy_q, busy_d;

  logic            accept, is_sub;
  logic [IdxW-1:0] tail_nxt, head_nxt;
  logic [63:0]     bytes;
  logic [16:0]     count_m1;

  assign accept   = push_i && !full_i;
  assign is_sub   = (action_i == ActRead) || (action_i == ActWrite);
  assign tail_nxt = (tail_q == IdxW'(QueueDepth - 1)) ? '0 : tail_q + 1'b1;
  assign head_nxt = (head_q == IdxW'(QueueDepth - 1)) ? '0 : head_q + 1'b1;
  assign bytes    = {47'd0, block_count_i} << cfg_i.bsl;
  assign count_m1 = block_count_i - 17'd1;

  always_comb begin
    tail_d      = tail_q;
    head_d      = head_q;
    phase_d     = phase_q;
    polls_d     = polls_q;
    busy_d      = busy_q;
    job_valid_o = 1'b0;
    job_o.kind     = JobFail;
    job_o.write    = (action_i == ActWrite);
    job_o.slot     = tail_q;
    job_o.new_idx  = tail_nxt;
    job_o.ok       = 1'b0;
    job_o.prp2_en  = (bytes > PageBytes);
    job_o.buf_addr = buffer_address_i;
    job_o.lba      = lba_i;
    job_o.dw12     = count_m1[15:0];
    if (accept) begin
      if (is_sub) begin
        job_valid_o = 1'b1;
        if (cfg_i.ready && !busy_q) begin
          job_o.kind = JobSubmit;
          tail_d     = tail_nxt;
          busy_d     = 1'b1;
          polls_d    = cfg_i.poll_limit;
        end
      end else if (action_i == ActStatus && busy_q) begin
        if (completion_status_i[0] != phase_q) begin
          // out of polls: give up and leave head and phase alone
          if (polls_q == '0) begin
            job_valid_o = 1'b1;
            busy_d      = 1'b0;
          end else begin
            polls_d = polls_q - 20'd1;
          end
        end else begin
          job_valid_o   = 1'b1;
          job_o.kind    = JobComplete;
          job_o.new_idx = head_nxt;
          job_o.ok      = (completion_status_i[15:1] == '0);
          head_d        = head_nxt;
          busy_d        = 1'b0;
          if (head_nxt == '0) begin
            phase_d = !phase_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q  <= '0;
      head_q  <= '0;
      phase_q <= 1'b1;
      polls_q <= '0;
      busy_q  <= 1'b0;
    end else begin
      tail_q  <= tail_d;
      head_q  <= head_d;
      phase_q <= phase_d;
      polls_q <= polls_d;
      busy_q  <= busy_d;
    end
  end

  `NVQP_ASSERT_NEXT(a_submit_sets_busy, accept && is_sub && cfg_i.ready && !busy_q, busy_q, "accepted submit did not mark command outstanding")
  `NVQP_ASSERT_NEXT(a_head_moves_on_match, accept && action_i == ActStatus && busy_q && completion_status_i[0] == phase_q, head_q == $past(head_nxt), "head did not advance on phase match")

endmodule

@@ rtl/core/nvqp_jobq.sv @@
// Short job queue between the front and back ends, register based.
// Depends on nvqp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module nvqp_jobq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  nvqp_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output nvqp_pkg::job_t data_o,
  output logic           empty_o
);
  import nvqp_pkg::*;

  localparam int unsigned PtrW = $clog2(JobqDepth);
  localparam int unsigned CntW = $clog2(JobqDepth + 1);

  job_t            mem_q [JobqDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(JobqDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  `NVQP_ASSERT(a_no_overflow, push_i |-> !full_o, "push into full job queue")
  `NVQP_ASSERT(a_no_underflow, pop_i |-> !empty_o, "pop from empty job queue")

endmodule

@@ rtl/core/nvqp_back.sv @@
// Back end: expands each job into one or two result beats and holds them in
// the output register. Depends on nvqp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module nvqp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  nvqp_pkg::cfg_t cfg_i,
  input  nvqp_pkg::job_t job_i,
  input  logic           q_empty_i,
  output logic           q_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output nvqp_pkg::res_t res_o
);
  import nvqp_pkg::*;

  logic beat_q, beat_d;
  logic out_vld_q, out_vld_d;
  res_t out_q, beat;
  logic load, last;

  assign load    = !q_empty_i && (!out_vld_q || pop_i);
  assign empty_o = !out_vld_q;
  assign res_o   = out_q;

  always_comb begin
    beat   = '0;
    last   = 1'b1;
    case (job_i.kind)
      JobSubmit: begin
        if (!beat_q) begin
          last        = 1'b0;
          beat.kind   = ResEntry;
          beat.idx    = job_i.slot;
          beat.opcode = job_i.write ? OpWrite : OpRead;
          beat.nsid   = cfg_i.nsid;
          beat.prp1   = job_i.buf_addr;
          beat.prp2   = job_i.prp2_en ? job_i.buf_addr + PageBytes : '0;
          beat.dw10   = job_i.lba[31:0];
          beat.dw11   = job_i.lba[63:32];
          beat.dw12   = job_i.dw12;
        end else begin
          beat.kind   = ResSqDb;
          beat.idx    = job_i.new_idx;
          beat.db_off = db_offset(SqDbSlot, cfg_i.stride);
        end
      end
      JobComplete: begin
        if (!beat_q) begin
          last        = 1'b0;
          beat.kind   = ResCqDb;
          beat.idx    = job_i.new_idx;
          beat.db_off = db_offset(CqDbSlot, cfg_i.stride);
        end else begin
          beat.kind = ResCmd;
          beat.ok   = job_i.ok;
        end
      end
      default: begin
        beat.kind = ResCmd;
        beat.ok   = 1'b0;
      end
    endcase
    beat.last = last;
  end

  assign q_pop_o = load && last;

  always_comb begin
    beat_d    = beat_q;
    out_vld_d = out_vld_q;
    if (pop_i && out_vld_q) begin
      out_vld_d = 1'b0;
    end
    if (load) begin
      out_vld_d = 1'b1;
      beat_d    = !last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= beat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      beat_q    <= beat_d;
      out_vld_q <= out_vld_d;
    end
  end

  `NVQP_ASSERT(a_second_beat_has_job, beat_q |-> !q_empty_i, "second beat pending with no job")
  `NVQP_ASSERT_NEXT(a_first_beat_not_last, load && !last, beat_q && !out_q.last, "first beat of a two-beat job marked last")

endmodule

@@ rtl/core/nvme_io_queue_pair_host.sv @@
// Top level of the NVMe I/O queue pair host block: configuration registers,
// front end, job queue and back end. Depends on nvqp_pkg and the nvqp_* modules.
//
// Host side of one NVMe I/O queue pair. Requests (read, write) and completion
// status polls enter through a push/full port; result beats leave through an
// empty/pop port. The front end takes one input beat per cycle while the job
// queue is not full and keeps the tail, head, phase and poll counter; a
// four-entry job queue decouples it from the back end, which emits one result
// beat per cycle through its output register while pop is held. A request or
// matching completion yields two beats; failures yield one; mismatching polls
// and stray status beats yield nothing. Sustained request/completion traffic is
// therefore bounded by the single result beat per cycle of the back end.
// Configuration is to be written by the user only while the block is idle; the
// block itself does not enforce this.
module nvme_io_queue_pair_host (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [nvqp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                 cfg_wdata_i,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  action_i,
  input  logic [63:0]                 lba_i,
  input  logic [16:0]                 block_count_i,
  input  logic [63:0]                 buffer_address_i,
  input  logic [15:0]                 completion_status_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [1:0]                  result_kind_o,
  output logic [9:0]                  queue_index_o,
  output logic [7:0]                  opcode_o,
  output logic [31:0]                 entry_namespace_o,
  output logic [63:0]                 prp_first_o,
  output logic [63:0]                 prp_second_o,
  output logic [31:0]                 dword_ten_o,
  output logic [31:0]                 dword_eleven_o,
  output logic [15:0]                 dword_twelve_o,
  output logic [18:0]                 doorbell_offset_o,
  output logic                        command_ok_o,
  output logic                        last_of_run_o
);
  import nvqp_pkg::*;

  cfg_t cfg_q;
  job_t job_in, job_out;
  logic job_push, q_full, q_empty, q_pop;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ready      <= 1'b0;
      cfg_q.nsid       <= '0;
      cfg_q.bsl        <= BslReset;
      cfg_q.stride     <= '0;
      cfg_q.poll_limit <= PollReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgReady:  cfg_q.ready      <= cfg_wdata_i[0];
        CfgNsid:   cfg_q.nsid       <= cfg_wdata_i;
        CfgBsl:    cfg_q.bsl        <= cfg_wdata_i[4:0];
        CfgStride: cfg_q.stride     <= cfg_wdata_i[3:0];
        CfgPoll:   cfg_q.poll_limit <= cfg_wdata_i[19:0];
        default:   cfg_q            <= cfg_q;
      endcase
    end
  end

  assign full = q_full;

  nvqp_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .push_i              (push),
    .full_i              (q_full),
    .action_i            (action_i),
    .lba_i               (lba_i),
    .block_count_i       (block_count_i),
    .buffer_address_i    (buffer_address_i),
    .completion_status_i (completion_status_i),
    .job_valid_o         (job_push),
    .job_o               (job_in)
  );

  nvqp_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (job_out),
    .empty_o (q_empty)
  );

  nvqp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .job_i     (job_out),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res)
  );

  assign result_kind_o     = res.kind;
  assign queue_index_o     = res.idx;
  assign opcode_o          = res.opcode;
  assign entry_namespace_o = res.nsid;
  assign prp_first_o       = res.prp1;
  assign prp_second_o      = res.prp2;
  assign dword_ten_o       = res.dw10;
  assign dword_eleven_o    = res.dw11;
  assign dword_twelve_o    = res.dw12;
  assign doorbell_offset_o = res.db_off;
  assign command_ok_o      = res.ok;
  assign last_of_run_o     = res.last;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for nvme_io_queue_pair_host: a directed table, then
// random phases of request/poll traffic checked beat by beat against a predictor.
// Depends on nvqp_pkg and the RTL of the block.
module testbench;
  import nvqp_pkg::*;

  localparam logic [1:0] ActSpare = 2'd3;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned TargetItems = 1550;

  typedef enum logic [1:0] {
    FromPredictor,
    NoBeat,
    FailBeat
  } beat_src_e;

  typedef struct packed {
    logic               is_write_op;
    logic [CfgIdxW-1:0] reg_idx;
    logic [31:0]        reg_val;
    logic [1:0]         action;
    logic [63:0]        lba;
    logic [16:0]        count;
    logic [63:0]        buf_addr;
    logic [15:0]        status;
    beat_src_e          src;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [31:0]         cfg_wdata_i = '0;
  logic                push = 1'b0;
  logic                full;
  logic [1:0]          action_i = '0;
  logic [63:0]         lba_i = '0;
  logic [16:0]         block_count_i = '0;
  logic [63:0]         buffer_address_i = '0;
  logic [15:0]         completion_status_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [1:0]          result_kind_o;
  logic [9:0]          queue_index_o;
  logic [7:0]          opcode_o;
  logic [31:0]         entry_namespace_o;
  logic [63:0]         prp_first_o;
  logic [63:0]         prp_second_o;
  logic [31:0]         dword_ten_o;
  logic [31:0]         dword_eleven_o;
  logic [15:0]         dword_twelve_o;
  logic [18:0]         doorbell_offset_o;
  logic                command_ok_o;
  logic                last_of_run_o;

  nvme_io_queue_pair_host uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .push                (push),
    .full                (full),
    .action_i            (action_i),
    .lba_i               (lba_i),
    .block_count_i       (block_count_i),
    .buffer_address_i    (buffer_address_i),
    .completion_status_i (completion_status_i),
    .empty               (empty),
    .pop                 (pop),
    .result_kind_o       (result_kind_o),
    .queue_index_o       (queue_index_o),
    .opcode_o            (opcode_o),
    .entry_namespace_o   (entry_namespace_o),
    .prp_first_o         (prp_first_o),
    .prp_second_o        (prp_second_o),
    .dword_ten_o         (dword_ten_o),
    .dword_eleven_o      (dword_eleven_o),
    .dword_twelve_o      (dword_twelve_o),
    .doorbell_offset_o   (doorbell_offset_o),
    .command_ok_o        (command_ok_o),
    .last_of_run_o       (last_of_run_o)
  );

  always #2 clk_i = ~clk_i;

  // register mirror
  logic        cfg_ready = 1'b0;
  logic [31:0] cfg_nsid = '0;
  logic [4:0]  cfg_bsl = BslReset;
  logic [3:0]  cfg_stride = '0;
  logic [19:0] cfg_poll = PollReset;

  // queue pair state as the host sees it
  logic [9:0]  sq_tail = '0;
  logic [9:0]  cq_head = '0;
  logic        cq_phase = 1'b1;
  logic [19:0] polls_left = '0;
  logic        cmd_pending = 1'b0;
  int unsigned live_items = 0;

  res_t        owed_beats[$];
  res_t        step_beats[$];
  row_t        directed_rows[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  logic        rx_calm = 1'b0;

  function automatic int unsigned idle_len(logic calm);
    int unsigned pick;
    pick = $urandom_range(99);
    if (calm || pick < 55) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [18:0] bell_offset(int unsigned slot);
    logic [31:0] spacing;
    spacing = 32'd4 << cfg_stride;
    return 19'(32'(DbBase) + slot * spacing);
  endfunction

  function automatic res_t fail_beat();
    res_t b;
    b = '0;
    b.kind = ResCmd;
    b.last = 1'b1;
    return b;
  endfunction

  // Work out the beats one accepted item causes and advance the host state.
  task automatic qp_advance(input row_t r);
    res_t        b;
    logic [63:0] xfer;
    if (r.action == ActRead || r.action == ActWrite) begin
      if (!cfg_ready || cmd_pending) begin
        step_beats.push_back(fail_beat());
      end else begin
        xfer = 64'(r.count) << cfg_bsl;
        b = '0;
        b.kind = ResEntry;
        b.idx = sq_tail;
        b.opcode = (r.action == ActRead) ? OpRead : OpWrite;
        b.nsid = cfg_nsid;
        b.prp1 = r.buf_addr;
        b.prp2 = (xfer > PageBytes) ? r.buf_addr + PageBytes : 64'd0;
        b.dw10 = r.lba[31:0];
        b.dw11 = r.lba[63:32];
        b.dw12 = 16'(r.count - 17'd1);
        step_beats.push_back(b);
        sq_tail = sq_tail + 10'd1;
        b = '0;
        b.kind = ResSqDb;
        b.idx = sq_tail;
        b.db_off = bell_offset(SqDbSlot);
        b.last = 1'b1;
        step_beats.push_back(b);
        cmd_pending = 1'b1;
        polls_left = cfg_poll;
      end
    end else if (r.action == ActStatus && cmd_pending) begin
      if (r.status[0] != cq_phase) begin
        if (polls_left == 0) begin
          cmd_pending = 1'b0;
          step_beats.push_back(fail_beat());
        end else begin
          polls_left = polls_left - 20'd1;
        end
      end else begin
        cq_head = cq_head + 10'd1;
        if (cq_head == 0) begin
          cq_phase = ~cq_phase;
        end
        b = '0;
        b.kind = ResCqDb;
        b.idx = cq_head;
        b.db_off = bell_offset(CqDbSlot);
        step_beats.push_back(b);
        cmd_pending = 1'b0;
        b = fail_beat();
        b.ok = (r.status[15:1] == 15'd0);
        step_beats.push_back(b);
      end
    end
  endtask

  task automatic apply_item(input row_t r, input int unsigned gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    action_i <= r.action;
    lba_i <= r.lba;
    block_count_i <= r.count;
    buffer_address_i <= r.buf_addr;
    completion_status_i <= r.status;
    do begin
      @(posedge clk_i);
    end while (full);
    live_items++;
    step_beats.delete();
    qp_advance(r);
    case (r.src)
      FromPredictor: foreach (step_beats[i]) owed_beats.push_back(step_beats[i]);
      FailBeat: owed_beats.push_back(fail_beat());
      default: ;
    endcase
  endtask

  // Hold the sender until every owed beat is out, then let the pipe empty.
  task automatic settle();
    push <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgReady:  cfg_ready = val[0];
      CfgNsid:   cfg_nsid = val;
      CfgBsl:    cfg_bsl = val[4:0];
      CfgStride: cfg_stride = val[3:0];
      CfgPoll:   cfg_poll = val[19:0];
      default: ;
    endcase
  endtask

  task automatic add_item(input logic [1:0] act, input logic [63:0] lba,
                          input logic [16:0] cnt, input logic [63:0] addr,
                          input logic [15:0] status, input beat_src_e src);
    row_t r;
    r = '0;
    r.action = act;
    r.lba = lba;
    r.count = cnt;
    r.buf_addr = addr;
    r.status = status;
    r.src = src;
    directed_rows.push_back(r);
  endtask

  task automatic add_write(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    row_t r;
    r = '0;
    r.is_write_op = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    directed_rows.push_back(r);
  endtask

  function automatic row_t make_req(logic [1:0] act);
    row_t        r;
    int unsigned pick;
    int unsigned page_cnt;
    r = '0;
    r.src = FromPredictor;
    r.action = act;
    pick = $urandom_range(99);
    r.lba = (pick < 5) ? '1 : (pick < 10) ? '0 : {$urandom, $urandom};
    page_cnt = (cfg_bsl > 12) ? 1 : (4096 >> cfg_bsl);
    pick = $urandom_range(99);
    if (pick < 50)      r.count = 17'($urandom_range(1, 16));
    else if (pick < 65) r.count = 17'(page_cnt + $urandom_range(0, 1));
    else if (pick < 85) r.count = 17'($urandom);
    else if (pick < 90) r.count = 17'd0;
    else if (pick < 95) r.count = 17'h1FFFF;
    else                r.count = 17'd65536;
    // near the top of memory the second page pointer wraps
    r.buf_addr = ($urandom_range(9) == 0) ? {44'hFFFFFFFFFFF, 20'($urandom)}
                                           : {$urandom, $urandom};
    r.status = 16'($urandom);
    return r;
  endfunction

  function automatic row_t make_poll(logic hit);
    row_t r;
    r = make_req(ActStatus);
    r.status[15:1] = (hit && $urandom_range(99) < 80) ? 15'd0 : 15'($urandom);
    r.status[0] = hit ? cq_phase : ~cq_phase;
    return r;
  endfunction

  task automatic configure_phase();
    logic [31:0] noise;
    int unsigned pick;
    noise = $urandom;
    write_reg(CfgReady, {noise[31:1], ($urandom_range(9) != 0)});
    pick = $urandom_range(9);
    write_reg(CfgNsid, (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFFFFFF : $urandom);
    pick = $urandom_range(9);
    write_reg(CfgBsl, {noise[31:5], (pick == 0) ? 5'd0 : (pick == 1) ? 5'd31 :
                       (pick < 5) ? 5'd9 : 5'($urandom)});
    write_reg(CfgStride, {noise[31:4], 4'($urandom)});
    pick = $urandom_range(99);
    write_reg(CfgPoll, {noise[31:20], (pick < 45) ? 20'($urandom_range(0, 3)) :
                        (pick < 60) ? 20'hFFFFF : (pick < 70) ? 20'd1 : 20'($urandom)});
  endtask

  initial begin
    row_t        r;
    logic        tx_calm;
    int unsigned phase_len;
    int unsigned misses;
    int unsigned n;

    add_item(ActRead, '1, 17'd1, '1, 16'h0000, FailBeat);       // not ready
    add_item(ActWrite, '0, 17'h1FFFF, '0, 16'hFFFF, FailBeat);
    add_item(ActStatus, '0, 17'd1, '0, 16'h0001, NoBeat);       // stray completion
    add_item(ActSpare, '1, '1, '1, '1, NoBeat);
    add_write(CfgReady, 32'd1);
    add_write(CfgNsid, 32'hFFFFFFFF);
    add_write(CfgStride, 32'd15);
    add_write(CfgPoll, 32'd2);
    add_item(ActRead, '1, 17'd1, '1, 16'h0000, FromPredictor);
    add_item(ActWrite, '0, 17'd2, '0, 16'h0000, FailBeat);     // busy
    add_item(ActStatus, '0, 17'd1, '0, 16'hFFFE, NoBeat);
    add_item(ActStatus, '0, 17'd1, '0, 16'h0000, NoBeat);
    add_item(ActStatus, '0, 17'd1, '0, 16'h0002, FailBeat);    // timeout
    add_item(ActWrite, 64'h0123456789ABCDEF, 17'd65536, 64'hFFFFFFFFFFFFF800, 16'h0,
             FromPredictor);
    add_item(ActStatus, '0, 17'd1, '0, 16'h0001, FromPredictor);
    add_item(ActWrite, '1, 17'd0, 64'h1000, 16'h0, FromPredictor); // zero count
    add_item(ActStatus, '0, 17'd1, '0, 16'hFFFF, FromPredictor);
    add_item(ActRead, 64'hFFFFFFFF00000000, 17'd9, '0, 16'h0, FromPredictor);
    add_item(ActStatus, '0, 17'd1, '0, 16'h0001, FromPredictor);
    add_write(CfgBsl, 32'd0);
    add_write(CfgStride, 32'd0);
    add_write(CfgNsid, 32'd0);
    add_write(CfgPoll, 32'd0);
    add_item(ActRead, '0, 17'd4096, '1, 16'h0, FromPredictor);  // exactly one page
    add_item(ActStatus, '0, 17'd1, '0, 16'h0000, FailBeat);
    add_item(ActWrite, '0, 17'd4097, 64'h8000000000000000, 16'h0, FromPredictor);
    add_item(ActStatus, '0, 17'd1, '0, 16'h0001, FromPredictor);
    add_write(CfgBsl, 32'd31);
    add_write(CfgPoll, 32'hFFFFF);
    add_item(ActRead, '1, 17'h1FFFF, '1, 16'h0, FromPredictor);
    add_item(ActSpare, '0, 17'd1, '0, 16'h0001, NoBeat);
    add_item(ActStatus, '0, 17'd1, '0, 16'h0001, FromPredictor);
    add_write(CfgReady, 32'd0);
    add_item(ActWrite, '1, 17'd3, '1, 16'h0, FailBeat);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write_op) begin
        settle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        apply_item(directed_rows[i], idle_len(1'b0));
      end
    end

    // random phases until the item target is reached
    while (live_items < TargetItems) begin
      settle();
      configure_phase();
      tx_calm = ($urandom_range(3) == 0);
      rx_calm = ($urandom_range(3) == 0);
      phase_len = live_items + $urandom_range(60, 200);
      if (phase_len > TargetItems) phase_len = TargetItems;
      while (live_items < phase_len) begin
        if ($urandom_range(99) < 82) begin
          apply_item(make_req($urandom_range(1) ? ActWrite : ActRead), idle_len(tx_calm));
          n = $urandom_range(99);
          misses = (n < 60) ? 0 : (n < 85) ? $urandom_range(1, 2) : $urandom_range(0, 6);
          repeat (misses) apply_item(make_poll(1'b0), idle_len(tx_calm));
          apply_item(make_poll(1'b1), idle_len(tx_calm));
        end else begin
          r = make_req(2'($urandom_range(3)));
          apply_item(r, idle_len(tx_calm));
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    res_t        want;
    int unsigned rx_hold;
    rx_hold = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (owed_beats.size() == 0) begin
          $error("result beat with nothing owed: kind %0d index %0d",
                 result_kind_o, queue_index_o);
          mismatches++;
        end else begin
          want = owed_beats.pop_front();
          check_field("result_kind", want.kind, result_kind_o);
          check_field("queue_index", want.idx, queue_index_o);
          check_field("opcode", want.opcode, opcode_o);
          check_field("entry_namespace", want.nsid, entry_namespace_o);
          check_field("prp_first", want.prp1, prp_first_o);
          check_field("prp_second", want.prp2, prp_second_o);
          check_field("dword_ten", want.dw10, dword_ten_o);
          check_field("dword_eleven", want.dw11, dword_eleven_o);
          check_field("dword_twelve", want.dw12, dword_twelve_o);
          check_field("doorbell_offset", want.db_off, doorbell_offset_o);
          check_field("command_ok", want.ok, command_ok_o);
          check_field("last_of_run", want.last, last_of_run_o);
        end
        if (!rx_calm && $urandom_range(99) < 30) rx_hold = idle_len(1'b0);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // end the run when no beat of any kind has moved for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || cfg_we_i) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/nvqp_pkg.sv
rtl/core/nvqp_front.sv
rtl/core/nvqp_jobq.sv
rtl/core/nvqp_back.sv
rtl/core/nvme_io_queue_pair_host.sv
verif/testbench.sv
